### rtl/srcomp_pkg.sv
// Shared types, register map, latencies and arithmetic helpers for the compensation core.
`default_nettype none
package srcomp_pkg;

	typedef struct packed {
		logic [19:0] raw_temp;
		logic [19:0] raw_press;
		logic [15:0] raw_hum;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] temperature;
		logic [31:0]        pressure;
		logic               pressure_valid;
		logic [16:0]        humidity;
		logic               humidity_valid;
	} result_t;

	// calibration registers as seen by the datapath
	typedef struct packed {
		logic [47:0] temp_coeffs;
		logic [63:0] press_lo;
		logic [63:0] press_hi;
		logic [15:0] press_nine;
		logic [63:0] hum_coeffs;
		logic        hum_en;
	} coeff_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_P9 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HUM      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_EN   = 3'd5;

	localparam int TEMP_LAT  = 3;
	localparam int PREP_LAT  = 7;
	localparam int DIV_STEPS = 64;
	localparam int DIV_LAT   = DIV_STEPS + 2;
	localparam int FIN_LAT   = 5;
	localparam int HUM_LAT   = 11;
	localparam int ALIGN_LAT = PREP_LAT + DIV_LAT + FIN_LAT - HUM_LAT;

	function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] n);
		return $signed(x) >>> n;
	endfunction

	// low 64 bits of a * b, split into two narrow partial products
	function automatic logic [63:0] mul64_s17(input logic [63:0] a, input logic signed [16:0] b);
		logic signed [50:0] lo;
		logic [31:0]        hi;
		lo = $signed({1'b0, a[31:0]}) * b;
		hi = a[63:32] * {{15{b[16]}}, b};
		return {{13{lo[50]}}, lo} + {hi, 32'b0};
	endfunction

endpackage
`default_nettype wire

### rtl/srcomp_temp.sv
// Temperature stages: fine temperature from the raw reading, three register stages.
`default_nettype none
module srcomp_temp
	import srcomp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire sample_t     sample,
	input  wire coeff_t      cfg,
	output logic             valid_s3,
	output logic [31:0]      tf_s3,
	output logic [19:0]      raw_press_s3,
	output logic [15:0]      raw_hum_s3
);
	logic [15:0]        t1, t2, t3;
	logic signed [17:0] diff_a;
	logic signed [33:0] prod_a;
	logic signed [16:0] d;
	logic signed [33:0] dd;
	logic signed [31:0] dd_sh;
	logic signed [47:0] mb;

	logic        valid_s1, valid_s2;
	logic [31:0] pa_s1, dd_s1, a_s2, mb_s2;
	logic [19:0] raw_press_s1, raw_press_s2;
	logic [15:0] raw_hum_s1, raw_hum_s2;

	assign t1 = cfg.temp_coeffs[15:0];
	assign t2 = cfg.temp_coeffs[31:16];
	assign t3 = cfg.temp_coeffs[47:32];

	assign diff_a = $signed({1'b0, sample.raw_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
	assign prod_a = diff_a * $signed(t2);
	assign d      = $signed({1'b0, sample.raw_temp[19:4]}) - $signed({1'b0, t1});
	assign dd     = d * d;
	assign dd_sh  = $signed(asr32(dd_s1, 5'd12));
	assign mb     = dd_sh * $signed(t3);

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1        <= prod_a[31:0];
			dd_s1        <= dd[31:0];
			raw_press_s1 <= sample.raw_press;
			raw_hum_s1   <= sample.raw_hum;
			a_s2         <= asr32(pa_s1, 5'd11);
			mb_s2        <= mb[31:0];
			raw_press_s2 <= raw_press_s1;
			raw_hum_s2   <= raw_hum_s1;
			tf_s3        <= a_s2 + asr32(mb_s2, 5'd14);
			raw_press_s3 <= raw_press_s2;
			raw_hum_s3   <= raw_hum_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end
endmodule
`default_nettype wire

### rtl/srcomp_prep.sv
// Pressure preparation: dividend and divisor from fine temperature and raw pressure.
`default_nettype none
module srcomp_prep
	import srcomp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire logic [31:0] tf,
	input  wire logic [19:0] raw_press,
	input  wire coeff_t      cfg,
	output logic             valid_s7,
	output logic [63:0]      num_s7,
	output logic [30:0]      den_s7
);
	logic [15:0] p1, p2, p3, p4, p5, p6;
	logic signed [33:0] v1;
	logic [33:0]        v1_neg;
	logic [63:0]        sq;
	logic signed [49:0] v1p5, v1p2;

	logic               valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic signed [33:0] v1_s1;
	logic [31:0]        vabs_s1;
	logic [20:0]        pr_s1, pr_s2, pr_s3, pr_s4;
	logic [63:0]        sq_s2;
	logic [49:0]        v1p5_s2, v1p2_s2;
	logic [63:0]        sqp6_s3, sqp3_s3, v2p_s3, v1p2_s3;
	logic [63:0]        v2_s4, v1b_s4;
	logic [63:0]        sum_s5, diff_s5;
	logic [63:0]        prod_s6, num_s6;

	assign p1 = cfg.press_lo[15:0];
	assign p2 = cfg.press_lo[31:16];
	assign p3 = cfg.press_lo[47:32];
	assign p4 = cfg.press_lo[63:48];
	assign p5 = cfg.press_hi[15:0];
	assign p6 = cfg.press_hi[31:16];

	assign v1     = $signed(tf) - 34'sd128000;
	assign v1_neg = 34'd0 - v1;
	assign sq     = vabs_s1 * vabs_s1;
	assign v1p5   = v1_s1 * $signed(p5);
	assign v1p2   = v1_s1 * $signed(p2);

	always_ff @(posedge clk) begin
		if (en) begin
			v1_s1   <= v1;
			vabs_s1 <= v1[33] ? v1_neg[31:0] : v1[31:0];
			pr_s1   <= 21'h100000 - {1'b0, raw_press};

			sq_s2   <= sq;
			v1p5_s2 <= v1p5;
			v1p2_s2 <= v1p2;
			pr_s2   <= pr_s1;

			sqp6_s3 <= mul64_s17(sq_s2, {p6[15], p6});
			sqp3_s3 <= mul64_s17(sq_s2, {p3[15], p3});
			v2p_s3  <= ({{14{v1p5_s2[49]}}, v1p5_s2} << 17) + ({{48{p4[15]}}, p4} << 35);
			v1p2_s3 <= {{14{v1p2_s2[49]}}, v1p2_s2} << 12;
			pr_s3   <= pr_s2;

			v2_s4   <= sqp6_s3 + v2p_s3;
			v1b_s4  <= asr64(sqp3_s3, 6'd8) + v1p2_s3;
			pr_s4   <= pr_s3;

			sum_s5  <= v1b_s4 + 64'h0000_8000_0000_0000;
			diff_s5 <= {12'b0, pr_s4, 31'b0} - v2_s4;

			prod_s6 <= mul64_s17(sum_s5, {1'b0, p1});
			num_s6  <= diff_s5 * 64'd3125;

			// arithmetic shift by 33 leaves a 31-bit signed divisor
			den_s7  <= prod_s6[63:33];
			num_s7  <= num_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end
endmodule
`default_nettype wire

### rtl/srcomp_div.sv
// Pipelined signed divider: 64-bit dividend by 31-bit divisor, one quotient bit per stage.
`default_nettype none
module srcomp_div
	import srcomp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire logic [63:0] num,
	input  wire logic [30:0] den,
	output logic             valid_o,
	output logic [63:0]      quot,
	output logic             zero
);
	logic [30:0] rem_s  [DIV_STEPS+1];
	logic [63:0] nq_s   [DIV_STEPS+1];
	logic [30:0] ud_s   [DIV_STEPS+1];
	logic        neg_s  [DIV_STEPS+1];
	logic        zero_s [DIV_STEPS+1];
	logic        v_s    [DIV_STEPS+1];
	logic [63:0] q_neg;

	// stage 0: magnitudes, result sign and zero-divisor flag
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			nq_s[0]   <= num[63] ? 64'd0 - num : num;
			ud_s[0]   <= den[30] ? 31'd0 - den : den;
			neg_s[0]  <= num[63] ^ den[30];
			zero_s[0] <= den == 31'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [31:0] rr;
		logic [31:0] rr_sub;
		logic        ge;

		assign rr     = {rem_s[k-1], nq_s[k-1][63]};
		assign rr_sub = rr - {1'b0, ud_s[k-1]};
		assign ge     = rr >= {1'b0, ud_s[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rr_sub[30:0] : rr[30:0];
				nq_s[k]   <= {nq_s[k-1][62:0], ge};
				ud_s[k]   <= ud_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				zero_s[k] <= zero_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	assign q_neg = 64'd0 - nq_s[DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			quot <= neg_s[DIV_STEPS] ? q_neg : nq_s[DIV_STEPS];
			zero <= zero_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= v_s[DIV_STEPS];
		end
	end
endmodule
`default_nettype wire

### rtl/srcomp_fin.sv
// Pressure finish: second-order correction of the quotient and offset term.
`default_nettype none
module srcomp_fin
	import srcomp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire logic [63:0] quot,
	input  wire logic        zero,
	input  wire coeff_t      cfg,
	output logic             valid_s5,
	output logic [31:0]      press_s5,
	output logic             pvalid_s5
);
	logic [15:0] p7, p8, p9;
	logic [63:0] ps;
	logic [63:0] sqlo;
	logic [31:0] sqx;
	logic [31:0] pr;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        zero_s1, zero_s2, zero_s3, zero_s4;
	logic [63:0] q_s1, q_s2, q_s3;
	logic [63:0] sqlo_s1, w2m_s1;
	logic [31:0] sqx_s1;
	logic [63:0] sq_s2, w2_s2;
	logic [63:0] w1m_s3, w2_s3;
	logic [63:0] sum_s4;

	assign p7 = cfg.press_hi[47:32];
	assign p8 = cfg.press_hi[63:48];
	assign p9 = cfg.press_nine;

	// square of the shifted quotient, low 64 bits from two 32-bit products
	assign ps   = asr64(quot, 6'd13);
	assign sqlo = ps[31:0] * ps[31:0];
	assign sqx  = ps[63:32] * ps[31:0];
	assign pr   = sum_s4[39:8] + {{12{p7[15]}}, p7, 4'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1      <= quot;
			zero_s1   <= zero;
			sqlo_s1   <= sqlo;
			sqx_s1    <= sqx;
			w2m_s1    <= mul64_s17(quot, {p8[15], p8});

			q_s2      <= q_s1;
			zero_s2   <= zero_s1;
			sq_s2     <= sqlo_s1 + {sqx_s1[30:0], 33'b0};
			w2_s2     <= asr64(w2m_s1, 6'd19);

			q_s3      <= q_s2;
			zero_s3   <= zero_s2;
			w1m_s3    <= mul64_s17(sq_s2, {p9[15], p9});
			w2_s3     <= w2_s2;

			zero_s4   <= zero_s3;
			sum_s4    <= q_s3 + asr64(w1m_s3, 6'd25) + w2_s3;

			press_s5  <= zero_s4 ? 32'd0 : pr;
			pvalid_s5 <= !zero_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end
endmodule
`default_nettype wire

### rtl/srcomp_hum.sv
// Humidity stages and final temperature scaling, fixed latency with no valid of its own.
`default_nettype none
module srcomp_hum
	import srcomp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] tf,
	input  wire logic [15:0] raw_hum,
	input  wire coeff_t      cfg,
	output logic [31:0]      temp_s11,
	output logic [16:0]      hum_s11
);
	logic [7:0]  h1, h3, h6;
	logic [15:0] h2;
	logic [11:0] h4, h5;
	logic [31:0] t5;
	logic [31:0] lsum;
	logic [31:0] xs;
	logic [31:0] y;
	logic [31:0] yc;

	logic [31:0] x_s1, m5_s2, m6_s2, m3_s2, l_s3, ra_s3, rb_s3;
	logic [31:0] l_s4, l_s5, l_s6, l_s7;
	logic [31:0] r1_s4, r2_s5, r3_s6, r4_s7;
	logic [31:0] x_s8, x_s9, x_s10, sq_s9, m_s10;
	logic [15:0] ah_s1, ah_s2;
	logic [31:0] temp_s1, temp_s2, temp_s3, temp_s4, temp_s5, temp_s6;
	logic [31:0] temp_s7, temp_s8, temp_s9, temp_s10;

	assign h1 = cfg.hum_coeffs[7:0];
	assign h2 = cfg.hum_coeffs[23:8];
	assign h3 = cfg.hum_coeffs[31:24];
	assign h4 = cfg.hum_coeffs[43:32];
	assign h5 = cfg.hum_coeffs[55:44];
	assign h6 = cfg.hum_coeffs[63:56];

	assign t5   = tf + {tf[29:0], 2'b00} + 32'd128;
	assign lsum = {2'b0, ah_s2, 14'b0} - {h4, 20'b0} - m5_s2 + 32'd16384;
	assign xs   = asr32(x_s8, 5'd15);
	assign y    = x_s10 - asr32(m_s10, 5'd4);

	// negative clamps to zero, top clamps to 100 %RH
	always_comb begin
		if (y[31]) begin
			yc = 32'd0;
		end else if (y > 32'd419430400) begin
			yc = 32'd419430400;
		end else begin
			yc = y;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= tf - 32'd76800;
			temp_s1  <= asr32(t5, 5'd8);
			ah_s1    <= raw_hum;

			m5_s2    <= x_s1 * {{20{h5[11]}}, h5};
			m6_s2    <= x_s1 * {{24{h6[7]}}, h6};
			m3_s2    <= x_s1 * {24'b0, h3};
			ah_s2    <= ah_s1;
			temp_s2  <= temp_s1;

			l_s3     <= asr32(lsum, 5'd15);
			ra_s3    <= asr32(m6_s2, 5'd10);
			rb_s3    <= asr32(m3_s2, 5'd11) + 32'd32768;
			temp_s3  <= temp_s2;

			r1_s4    <= ra_s3 * rb_s3;
			l_s4     <= l_s3;
			temp_s4  <= temp_s3;

			r2_s5    <= asr32(r1_s4, 5'd10) + 32'd2097152;
			l_s5     <= l_s4;
			temp_s5  <= temp_s4;

			r3_s6    <= r2_s5 * {{16{h2[15]}}, h2};
			l_s6     <= l_s5;
			temp_s6  <= temp_s5;

			r4_s7    <= asr32(r3_s6 + 32'd8192, 5'd14);
			l_s7     <= l_s6;
			temp_s7  <= temp_s6;

			x_s8     <= l_s7 * r4_s7;
			temp_s8  <= temp_s7;

			sq_s9    <= xs * xs;
			x_s9     <= x_s8;
			temp_s9  <= temp_s8;

			m_s10    <= asr32(sq_s9, 5'd7) * {24'b0, h1};
			x_s10    <= x_s9;
			temp_s10 <= temp_s9;

			hum_s11  <= cfg.hum_en ? yc[28:12] : 17'd0;
			temp_s11 <= temp_s10;
		end
	end
endmodule
`default_nettype wire

### rtl/sensor_reading_compensation_core.sv
// Top level: calibration registers, compensation pipeline and two-entry output buffer.
//
//  channel   direction  handshake                   payload
//  sample    in         sample_valid/sample_ready   sample_t: raw_temp, raw_press, raw_hum
//  result    out        result_valid/result_ready   result_t: temperature .. humidity_valid
//  cfg       in         cfg_we                      cfg_idx, cfg_wdata
//
// One sample per cycle unless the output buffer stalls; a sample passes the temperature,
// preparation, divider and finish stages, then the output buffer; the divider dominates.
// All stages advance together while the output buffer has room or is being drained.
// Reset clears the valid bits and the buffer and loads the calibration reset values.
`default_nettype none
module sensor_reading_compensation_core
	import srcomp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  sample_valid,
	output logic                       sample_ready,
	input  wire sample_t               sample,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output result_t                    result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
	coeff_t      cfg_q;
	logic        en;

	logic        t_valid;
	logic [31:0] tf;
	logic [19:0] t_press;
	logic [15:0] t_hum;

	logic        p_valid;
	logic [63:0] p_num;
	logic [30:0] p_den;

	logic        d_valid;
	logic [63:0] d_quot;
	logic        d_zero;

	logic        f_valid;
	logic [31:0] f_press;
	logic        f_pvalid;

	logic [31:0] h_temp;
	logic [16:0] h_hum;

	logic [48:0] aln_s [ALIGN_LAT];

	result_t     buf_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q        <= '0;
			cfg_q.hum_en <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TEMP:     cfg_q.temp_coeffs <= cfg_wdata[47:0];
				REG_PRESS_LO: cfg_q.press_lo    <= cfg_wdata;
				REG_PRESS_HI: cfg_q.press_hi    <= cfg_wdata;
				REG_PRESS_P9: cfg_q.press_nine  <= cfg_wdata[15:0];
				REG_HUM:      cfg_q.hum_coeffs  <= cfg_wdata;
				REG_HUM_EN:   cfg_q.hum_en      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// the whole pipeline moves unless the output buffer is full and not draining
	assign en           = (cnt_q != 2'd2) || result_ready;
	assign sample_ready = en;

	srcomp_temp u_temp (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (sample_valid),
		.sample       (sample),
		.cfg          (cfg_q),
		.valid_s3     (t_valid),
		.tf_s3        (tf),
		.raw_press_s3 (t_press),
		.raw_hum_s3   (t_hum)
	);

	srcomp_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (t_valid),
		.tf        (tf),
		.raw_press (t_press),
		.cfg       (cfg_q),
		.valid_s7  (p_valid),
		.num_s7    (p_num),
		.den_s7    (p_den)
	);

	srcomp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (p_valid),
		.num      (p_num),
		.den      (p_den),
		.valid_o  (d_valid),
		.quot     (d_quot),
		.zero     (d_zero)
	);

	srcomp_fin u_fin (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d_valid),
		.quot      (d_quot),
		.zero      (d_zero),
		.cfg       (cfg_q),
		.valid_s5  (f_valid),
		.press_s5  (f_press),
		.pvalid_s5 (f_pvalid)
	);

	srcomp_hum u_hum (
		.clk      (clk),
		.en       (en),
		.tf       (tf),
		.raw_hum  (t_hum),
		.cfg      (cfg_q),
		.temp_s11 (h_temp),
		.hum_s11  (h_hum)
	);

	// hold temperature and humidity until the pressure of the same beat arrives
	always_ff @(posedge clk) begin
		if (en) begin
			aln_s[0] <= {h_temp, h_hum};
		end
	end

	for (genvar i = 1; i < ALIGN_LAT; i++) begin : g_aln
		always_ff @(posedge clk) begin
			if (en) begin
				aln_s[i] <= aln_s[i-1];
			end
		end
	end

	assign push = f_valid && en;
	assign pop  = result_valid && result_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q].temperature    <= aln_s[ALIGN_LAT-1][48:17];
			buf_q[wr_ptr_q].pressure       <= f_press;
			buf_q[wr_ptr_q].pressure_valid <= f_pvalid;
			buf_q[wr_ptr_q].humidity       <= aln_s[ALIGN_LAT-1][16:0];
			buf_q[wr_ptr_q].humidity_valid <= cfg_q.hum_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign result_valid = cnt_q != 2'd0;
	assign result       = buf_q[rd_ptr_q];
endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the sensor reading compensation core: directed and random samples.
module tb;
	import srcomp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd6;   // unmapped index, write must be ignored
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE      = 120;                  // > pipeline latency plus output buffer

	localparam logic [47:0] CAL_TEMP  = {-16'sd1000, 16'sd26435, 16'd27504};
	localparam logic [63:0] CAL_P_LO  = {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477};
	localparam logic [63:0] CAL_P_HI  = {-16'sd14600, 16'sd15500, -16'sd7, 16'sd140};
	localparam logic [15:0] CAL_P9    = 16'sd6000;
	localparam logic [63:0] CAL_HUM   = {8'sd30, 12'sd50, 12'sd324, 8'd0, 16'sd362, 8'd75};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	sample_t sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// local copy of the calibration registers
	logic [47:0] k_temp;
	logic [63:0] k_plo, k_phi, k_hum;
	logic [15:0] k_nine;
	logic        k_hum_en;

	result_t pending_q[$];
	result_t want;
	logic idling_on = 1'b1;
	int stall_left = 0;
	int quiet = 0;
	int n_samples = 0, n_results = 0, n_errors = 0, n_no_press = 0, n_phases = 0;

	sensor_reading_compensation_core uut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	function automatic result_t compensate(input sample_t s);
		logic [31:0] at, t1, t2, t3, a, d, b, tf, x, l, r;
		logic [31:0] h1, h2, h3, h4, h5, h6;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] v1, v2, pp, num, un, ud, q, w1, w2;
		result_t o;
		o = '0;
		at = {12'b0, s.raw_temp};
		t1 = {16'b0, k_temp[15:0]};
		t2 = {{16{k_temp[31]}}, k_temp[31:16]};
		t3 = {{16{k_temp[47]}}, k_temp[47:32]};
		a = sra32(((at >> 3) - (t1 << 1)) * t2, 11);
		d = (at >> 4) - t1;
		b = sra32(sra32(d * d, 12) * t3, 14);
		tf = a + b;
		o.temperature = sra32(tf * 32'd5 + 32'd128, 8);

		p1 = {48'b0, k_plo[15:0]};
		p2 = {{48{k_plo[31]}}, k_plo[31:16]};
		p3 = {{48{k_plo[47]}}, k_plo[47:32]};
		p4 = {{48{k_plo[63]}}, k_plo[63:48]};
		p5 = {{48{k_phi[15]}}, k_phi[15:0]};
		p6 = {{48{k_phi[31]}}, k_phi[31:16]};
		p7 = {{48{k_phi[47]}}, k_phi[47:32]};
		p8 = {{48{k_phi[63]}}, k_phi[63:48]};
		p9 = {{48{k_nine[15]}}, k_nine};
		v1 = {{32{tf[31]}}, tf} - 64'd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
		v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
		if (v1 != 64'd0) begin
			pp = 64'd1048576 - {44'b0, s.raw_press};
			num = ((pp << 31) - v2) * 64'd3125;
			// truncating signed divide; most negative / -1 wraps onto itself
			un = num[63] ? 64'd0 - num : num;
			ud = v1[63] ? 64'd0 - v1 : v1;
			q = un / ud;
			pp = (num[63] != v1[63]) ? 64'd0 - q : q;
			w1 = sra64(p9 * sra64(pp, 13) * sra64(pp, 13), 25);
			w2 = sra64(p8 * pp, 19);
			pp = sra64(pp + w1 + w2, 8) + (p7 << 4);
			o.pressure = pp[31:0];
			o.pressure_valid = 1'b1;
		end

		if (k_hum_en) begin
			h1 = {24'b0, k_hum[7:0]};
			h2 = {{16{k_hum[23]}}, k_hum[23:8]};
			h3 = {24'b0, k_hum[31:24]};
			h4 = {{20{k_hum[43]}}, k_hum[43:32]};
			h5 = {{20{k_hum[55]}}, k_hum[55:44]};
			h6 = {{24{k_hum[63]}}, k_hum[63:56]};
			x = tf - 32'd76800;
			l = sra32(({16'b0, s.raw_hum} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
			r = sra32(x * h6, 10) * (sra32(x * h3, 11) + 32'd32768);
			r = sra32(r, 10) + 32'd2097152;
			r = sra32(r * h2 + 32'd8192, 14);
			x = l * r;
			x = x - sra32(sra32(sra32(x, 15) * sra32(x, 15), 7) * h1, 4);
			if (x[31])
				x = 32'd0;
			else if (x > 32'd419430400)
				x = 32'd419430400;
			o.humidity = x[28:12];
			o.humidity_valid = 1'b1;
		end
		return o;
	endfunction

	// one beat on the cfg port per call; caller drops cfg_we afterwards
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_TEMP:     k_temp = data[47:0];
			REG_PRESS_LO: k_plo = data;
			REG_PRESS_HI: k_phi = data;
			REG_PRESS_P9: k_nine = data[15:0];
			REG_HUM:      k_hum = data;
			REG_HUM_EN:   k_hum_en = data[0];
			default:      ;
		endcase
	endtask

	task automatic load_cal(input logic [63:0] tc, input logic [63:0] plo, input logic [63:0] phi,
			input logic [63:0] p9, input logic [63:0] hc, input logic [63:0] en);
		write_reg(REG_TEMP, tc);
		write_reg(REG_PRESS_LO, plo);
		write_reg(REG_PRESS_HI, phi);
		write_reg(REG_PRESS_P9, p9);
		write_reg(REG_HUM, hc);
		write_reg(REG_HUM_EN, en);
		write_reg(REG_NONE, {$urandom, $urandom});
		cfg_we <= 1'b0;
		@(posedge clk);
		n_phases++;
	endtask

	task automatic send_sample(input sample_t s);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		sample <= s;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
		pending_q.push_back(compensate(s));
		n_samples++;
	endtask

	task automatic drain;
		sample_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic sample_t rand_sample();
		sample_t s;
		s.raw_temp  = $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? 20'hFFFFF : 20'h0)
			: 20'($urandom);
		s.raw_press = $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? 20'hFFFFF : 20'h0)
			: 20'($urandom);
		s.raw_hum   = $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
			: 16'($urandom);
		return s;
	endfunction

	// result side: random stall bursts on result_ready, started only while idling_on is set
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 6) == 0) begin
			stall_left <= $urandom_range(0, 8);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			n_results++;
			if (pending_q.size() == 0) begin
				$display("%0t unexpected result beat: got %p", $time, result);
				n_errors++;
			end else begin
				want = pending_q.pop_front();
				if (result.temperature !== want.temperature) begin
					$display("%0t temperature: expected %0d actual %0d", $time,
						want.temperature, result.temperature);
					n_errors++;
				end
				if (result.pressure !== want.pressure) begin
					$display("%0t pressure: expected %h actual %h", $time,
						want.pressure, result.pressure);
					n_errors++;
				end
				if (result.pressure_valid !== want.pressure_valid) begin
					$display("%0t pressure_valid: expected %b actual %b", $time,
						want.pressure_valid, result.pressure_valid);
					n_errors++;
				end
				if (result.humidity !== want.humidity) begin
					$display("%0t humidity: expected %0d actual %0d", $time,
						want.humidity, result.humidity);
					n_errors++;
				end
				if (result.humidity_valid !== want.humidity_valid) begin
					$display("%0t humidity_valid: expected %b actual %b", $time,
						want.humidity_valid, result.humidity_valid);
					n_errors++;
				end
				if (!want.pressure_valid)
					n_no_press++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t timeout: no beat for %0d cycles", $time, quiet);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// reset values: p1 = 0 gives a zero divisor on every sample
	task automatic test_reset_values;
		k_temp = '0;
		k_plo = '0;
		k_phi = '0;
		k_nine = '0;
		k_hum = '0;
		k_hum_en = 1'b1;
		send_sample('{20'h0, 20'h0, 16'h0});
		send_sample('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
		send_sample('{20'h80000, 20'h6A5C0, 16'h6E00});
		drain();
	endtask

	task automatic test_field_extremes;
		load_cal(CAL_TEMP, CAL_P_LO, CAL_P_HI, CAL_P9, CAL_HUM, 64'd1);
		send_sample('{20'h0, 20'h0, 16'h0});
		send_sample('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
		send_sample('{20'hAAAAA, 20'h55555, 16'hAAAA});
		send_sample('{20'h55555, 20'hAAAAA, 16'h5555});
		send_sample('{20'h7E8F0, 20'h5A3C0, 16'h6A00});
		send_sample('{20'h0, 20'hFFFFF, 16'hFFFF});
		send_sample('{20'hFFFFF, 20'h0, 16'h0});
		send_sample('{20'h83000, 20'h65000, 16'h8000});
		drain();
	endtask

	// t/p coefficients chosen so the pressure divisor comes out as exactly minus one
	task automatic test_divisor_minus_one;
		load_cal({16'sd0, 16'sd16384, 16'd57539}, {16'sd0, 16'sd0, 16'sd32767, 16'd1},
			{$urandom, $urandom}, 64'($urandom), {$urandom, $urandom}, 64'd1);
		send_sample('{20'h8, 20'h0, 16'h0});
		send_sample('{20'hF, 20'hFFFFF, 16'hFFFF});
		send_sample('{20'hA, 20'h80000, 16'h1234});
		drain();
	endtask

	task automatic test_humidity_disabled;
		load_cal(CAL_TEMP, CAL_P_LO, CAL_P_HI, CAL_P9, CAL_HUM, 64'hFFFF_FFFF_FFFF_FFFE);
		send_sample('{20'h7E8F0, 20'h5A3C0, 16'hFFFF});
		send_sample('{20'h0, 20'hFFFFF, 16'h0});
		send_sample('{20'hFFFFF, 20'h0, 16'h6000});
		drain();
	endtask

	task automatic test_random_phase(input int kind, input int count);
		logic [63:0] j;
		j = {$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF;
		case (kind)
			0: load_cal(CAL_TEMP ^ j[47:0], CAL_P_LO ^ j, CAL_P_HI ^ j, CAL_P9 ^ j[15:0],
				CAL_HUM ^ j, 64'd1);
			1: load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom));
			2: load_cal('1, '1, '1, '1, '1, 64'd1);
			default: load_cal(CAL_TEMP, CAL_P_LO, CAL_P_HI, CAL_P9,
				{$urandom, $urandom}, 64'd1);
		endcase
		repeat (count) send_sample(rand_sample());
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_field_extremes();
		test_divisor_minus_one();
		test_humidity_disabled();
		test_random_phase(0, 120);
		test_random_phase(1, 120);
		test_random_phase(2, 60);
		test_random_phase(3, 120);
		test_random_phase(1, 60);
		idling_on = 1'b0;
		test_random_phase(0, 120);
		$display("covered %0d samples, %0d results, %0d calibration settings", n_samples,
			n_results, n_phases);
		$display("zero-divisor results: %0d, mismatches: %0d", n_no_press, n_errors);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
rtl/srcomp_pkg.sv
rtl/srcomp_temp.sv
rtl/srcomp_prep.sv
rtl/srcomp_div.sv
rtl/srcomp_fin.sv
rtl/srcomp_hum.sv
rtl/sensor_reading_compensation_core.sv
bench/tb.sv
